@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an antecedent is followed in the next cycle by a consequent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ssmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssmp_pkg;

  // Store geometry.
  localparam int DEPTH = 16;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int MODE_W = 2;
  localparam int STORED_COUNT_W = 5;

  // Operation codes carried on the mode port.
  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

  // Value shown as the smallest entry of an empty store.
  localparam logic signed [DATA_W-1:0] EMPTY_TOP = -32'sd1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_stack_min_priority_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Min priority queue kept as a sorted row of cells, smallest value on top.
// done is high in the result state, which follows the update state after the accepting edge.
// A new transaction is accepted only while idle; busy covers the update and result states.
// The store updates in the execute state through per-cell compares and neighbor shifts.
// Reset (synchronous, active high) empties the store; the receiver cannot stall results.
module sorted_stack_min_priority_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [ssmp_pkg::MODE_W-1:0]            mode,
  input  wire logic signed [ssmp_pkg::DATA_W-1:0]     push_value,
  output logic                                        done,
  output logic signed [ssmp_pkg::DATA_W-1:0]          top_value,
  output logic                                        is_empty,
  output logic [ssmp_pkg::STORED_COUNT_W-1:0]         stored_count,
  output logic                                        overflow
);
  import ssmp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer for each transaction.
  ssmp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Sorted store and result fields.
  ssmp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .push_value   (push_value),
    .status       (status),
    .top_value    (top_value),
    .is_empty     (is_empty),
    .stored_count (stored_count),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ssmp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ssmp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ssmp_pkg::dp_status_t status,
  output ssmp_pkg::dp_cmd_t       cmd,
  output logic                    busy,
  output logic                    done
);
  import ssmp_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: an update state for the store, then a result state, then back to idle.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
      end
      ST_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `ASSERT_CLK(a_done_after_exec, !done || $past(cmd.execute), "result without an update")
  `ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && cmd.execute, "accepted item not run")
  `ASSERT_CLK(a_status_sane, !(status.full && status.empty), "store both full and empty")

endmodule

`default_nettype wire

@@ hw/rtl/ssmp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ssmp_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire ssmp_pkg::dp_cmd_t                      cmd,
  input  wire logic [ssmp_pkg::MODE_W-1:0]            mode,
  input  wire logic signed [ssmp_pkg::DATA_W-1:0]     push_value,
  output ssmp_pkg::dp_status_t                        status,
  output logic signed [ssmp_pkg::DATA_W-1:0]          top_value,
  output logic                                        is_empty,
  output logic [ssmp_pkg::STORED_COUNT_W-1:0]         stored_count,
  output logic                                        overflow
);
  import ssmp_pkg::*;

  // Captured operation.
  logic [MODE_W-1:0]        op_mode;
  logic signed [DATA_W-1:0] op_value;

  // Sorted cells, smallest at index 0, and the fill count.
  logic signed [DATA_W-1:0] entry      [DEPTH];
  logic signed [DATA_W-1:0] entry_next [DEPTH];
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic                     overflow_next;

  // Per-cell result of comparing the pushed value: the cell is held and not above it.
  logic [DEPTH-1:0] keep_cell;

  logic full;
  logic empty;
  logic do_push;
  logic do_pop;
  logic drop_push;
  logic [COUNT_W+STORED_COUNT_W-1:0] count_ext;

  assign full = (count == COUNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = (op_mode == MODE_PUSH) && !full;
  assign do_pop = (op_mode == MODE_POP) && !empty;
  assign drop_push = (op_mode == MODE_PUSH) && full;

  // Capture the operation when the transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode <= mode;
      op_value <= push_value;
    end
  end

  // Each cell compares itself with the pushed value and picks its next content.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep_cell[i] = (COUNT_W'(i) < count) && !(op_value < entry[i]);
    end
    for (int i = 0; i < DEPTH; i++) begin
      entry_next[i] = entry[i];
    end
    if (do_push) begin
      // The top cell takes the new value unless it is kept.
      if (!keep_cell[0]) begin
        entry_next[0] = op_value;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!keep_cell[i]) begin
          if (keep_cell[i-1]) begin
            entry_next[i] = op_value;
          end else begin
            entry_next[i] = entry[i-1];
          end
        end
      end
    end else if (do_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        entry_next[i] = entry[i+1];
      end
    end
  end

  // Count and overflow flag updates.
  always_comb begin
    count_next = count;
    overflow_next = 1'b0;
    if (do_push) begin
      count_next = count + COUNT_W'(1);
    end else if (do_pop) begin
      count_next = count - COUNT_W'(1);
    end
    if (drop_push) begin
      overflow_next = 1'b1;
    end
  end

  // Cell contents need no reset: only cells below the count are read.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry[i] <= entry_next[i];
      end
    end
  end

  // Control state of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      overflow <= 1'b0;
    end else if (cmd.execute) begin
      count <= count_next;
      overflow <= overflow_next;
    end
  end

  // Result fields.
  assign count_ext = {{STORED_COUNT_W{1'b0}}, count};
  assign top_value = empty ? EMPTY_TOP : entry[0];
  assign is_empty = empty;
  assign stored_count = count_ext[STORED_COUNT_W-1:0];
  assign status = {full, empty};

  `ASSERT_CLK(a_count_bound, count <= COUNT_W'(DEPTH), "count beyond depth")
  `ASSERT_NEXT(a_overflow_when_full, cmd.execute && drop_push, overflow && full, "drop unflagged")

endmodule

`default_nettype wire
